// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// The expression must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// ----- hw/rtl/leb_pkg.sv -----
// Shared types and constants of the line edit buffer.
`timescale 1ns / 1ps

package leb_pkg;

  localparam int unsigned CharW = 8;
  localparam int unsigned CfgIdxW = 3;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgEraseChar   = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgKillChar    = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgLineEndChar = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgStopChar    = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgStopEnable  = 3'd4;

  // Register values after reset.
  localparam logic [CharW-1:0] EraseCharRst   = 8'd35;
  localparam logic [CharW-1:0] KillCharRst    = 8'd64;
  localparam logic [CharW-1:0] LineEndCharRst = 8'd10;
  localparam logic [CharW-1:0] StopCharRst    = 8'd33;
  localparam logic             StopEnableRst  = 1'b0;

  // Controller states: take characters, drain the stored line, send the line end.
  typedef enum logic [1:0] {
    StIdle  = 2'd0,
    StDrain = 2'd1,
    StEndl  = 2'd2
  } leb_state_e;

  // Controls broadcast to every cell of the chain.
  typedef struct packed {
    logic append;
    logic shift;
  } leb_ctrl_t;

endpackage

// ----- hw/rtl/line_edit_buffer.sv -----
// Line edit buffer: a chain of character cells with erase, kill and line flush control.
// An ordinary character is stored in the cell chain when it is taken; a line end shows its first
// request on the output in the next cycle. Throughput: one edit character per cycle while idle;
// a flushed line of N characters holds the input for N+1 output requests, one per cycle while
// out_ready_i is high, as cell 0 feeds the output while the chain shifts.
// Reset: asynchronous, active low; clears the fill count, flags and registers, not the cells.
`timescale 1ns / 1ps

module line_edit_buffer #(
  parameter int unsigned LINE_DEPTH = 63
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [leb_pkg::CharW-1:0]     in_char_i,
  input  logic                          end_of_text_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [leb_pkg::CharW-1:0]     out_char_o,
  output logic                          line_done_o,
  output logic                          chars_lost_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [leb_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [leb_pkg::CharW-1:0]     cfg_data_i
);

  localparam int unsigned CntW = $clog2(LINE_DEPTH + 1);

  leb_pkg::leb_state_e       state_q, state_d;
  logic [CntW-1:0]           fill_q, fill_d;
  logic                      started_q, started_d;
  logic                      lost_q, lost_d;
  logic [leb_pkg::CharW-1:0] erase_q, kill_q, line_end_q, stop_q;
  logic                      stop_en_q;
  leb_pkg::leb_ctrl_t        ctrl;
  logic                      in_acc, out_acc, is_stop, is_end;
  logic [leb_pkg::CharW-1:0] cell_data [LINE_DEPTH];
  logic [leb_pkg::CharW-1:0] cell_next [LINE_DEPTH];
  logic [LINE_DEPTH-1:0]     cell_sel;

  // Configuration registers; out-of-range indexes are ignored.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      erase_q    <= leb_pkg::EraseCharRst;
      kill_q     <= leb_pkg::KillCharRst;
      line_end_q <= leb_pkg::LineEndCharRst;
      stop_q     <= leb_pkg::StopCharRst;
      stop_en_q  <= leb_pkg::StopEnableRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        leb_pkg::CfgEraseChar:   erase_q    <= cfg_data_i;
        leb_pkg::CfgKillChar:    kill_q     <= cfg_data_i;
        leb_pkg::CfgLineEndChar: line_end_q <= cfg_data_i;
        leb_pkg::CfgStopChar:    stop_q     <= cfg_data_i;
        leb_pkg::CfgStopEnable:  stop_en_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Handshakes and character classification.
  assign in_ready_o = (state_q == leb_pkg::StIdle);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_acc    = out_valid_o && out_ready_i;
  assign is_stop    = end_of_text_i || (stop_en_q && (in_char_i == stop_q));
  assign is_end     = !is_stop && (in_char_i == line_end_q);

  // Next state, fill count and cell controls.
  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    started_d   = started_q;
    lost_d      = lost_q;
    ctrl.append = 1'b0;
    ctrl.shift  = 1'b0;
    case (state_q)
      leb_pkg::StIdle: begin
        if (in_acc) begin
          if (is_end || (is_stop && started_q)) begin
            state_d = (fill_q == '0) ? leb_pkg::StEndl : leb_pkg::StDrain;
          end else if (is_stop) begin
            fill_d = '0;
            lost_d = 1'b0;
          end else begin
            started_d = 1'b1;
            if (in_char_i == erase_q) begin
              if (fill_q != '0) begin
                fill_d = fill_q - CntW'(1);
              end
            end else if (in_char_i == kill_q) begin
              fill_d = '0;
            end else if (fill_q < CntW'(LINE_DEPTH)) begin
              ctrl.append = 1'b1;
              fill_d      = fill_q + CntW'(1);
            end else begin
              lost_d = 1'b1;
            end
          end
        end
      end
      leb_pkg::StDrain: begin
        if (out_acc) begin
          ctrl.shift = 1'b1;
          fill_d     = fill_q - CntW'(1);
          if (fill_q == CntW'(1)) begin
            state_d = leb_pkg::StEndl;
          end
        end
      end
      leb_pkg::StEndl: begin
        if (out_acc) begin
          fill_d    = '0;
          started_d = 1'b0;
          lost_d    = 1'b0;
          state_d   = leb_pkg::StIdle;
        end
      end
      default: begin
        state_d = leb_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= leb_pkg::StIdle;
      fill_q    <= '0;
      started_q <= 1'b0;
      lost_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      fill_q    <= fill_d;
      started_q <= started_d;
      lost_q    <= lost_d;
    end
  end

  // Chain of cells: each holds one character and passes it toward cell 0 while draining.
  for (genvar k = 0; k < LINE_DEPTH; k++) begin : g_cell
    assign cell_sel[k]  = (fill_q == CntW'(k));
    if (k == LINE_DEPTH - 1) begin : g_tail
      assign cell_next[k] = '0;
    end else begin : g_link
      assign cell_next[k] = cell_data[k+1];
    end
    leb_cell u_cell (
      .clk_i  (clk_i),
      .ctrl_i (ctrl),
      .sel_i  (cell_sel[k]),
      .char_i (in_char_i),
      .next_i (cell_next[k]),
      .data_o (cell_data[k])
    );
  end

  // Output request comes straight from registers: cell 0 or the line-end character.
  assign out_valid_o  = (state_q != leb_pkg::StIdle);
  assign line_done_o  = (state_q == leb_pkg::StEndl);
  assign out_char_o   = line_done_o ? line_end_q : cell_data[0];
  assign chars_lost_o = lost_q;

endmodule

// ----- hw/rtl/leb_cell.sv -----
// One character cell of the line store chain.
`timescale 1ns / 1ps

module leb_cell (
  input  logic                        clk_i,
  input  leb_pkg::leb_ctrl_t          ctrl_i,
  input  logic                        sel_i,
  input  logic [leb_pkg::CharW-1:0]   char_i,
  input  logic [leb_pkg::CharW-1:0]   next_i,
  output logic [leb_pkg::CharW-1:0]   data_o
);

  logic [leb_pkg::CharW-1:0] data_q;
  logic [leb_pkg::CharW-1:0] data_d;

  // Take the neighbor's character while draining, or the new one when this is the fill slot.
  always_comb begin
    data_d = data_q;
    if (ctrl_i.shift) begin
      data_d = next_i;
    end else if (ctrl_i.append && sel_i) begin
      data_d = char_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

// ----- hw/rtl/leb_checker.sv -----
// Port-level checker for the line edit buffer, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module leb_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input logic line_done_o,
  input logic chars_lost_o
);

  // A pending output request is held until it is taken.
  `ASSERT_CLK(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o, "output request dropped")

  // The block does not take input while a line is being sent.
  `ASSERT_NEVER(a_no_overlap, clk_i, rst_ni, in_ready_o && out_valid_o, "input taken during a flush")

  // After the closing line end is taken the output goes quiet.
  `ASSERT_CLK(a_done_ends, clk_i, rst_ni, out_valid_o && out_ready_i && line_done_o |=> !out_valid_o, "output continued after line end")

  // The lost flag stays the same over the whole line.
  `ASSERT_CLK(a_lost_run, clk_i, rst_ni, out_valid_o && out_ready_i && !line_done_o |=> chars_lost_o == $past(chars_lost_o), "lost flag changed within a line")

endmodule

bind line_edit_buffer leb_checker u_leb_checker (.*);
